### rtl/olir_pkg.sv
`default_nettype none

package olir_pkg;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 5;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH    = 3'd0,
    KIND_POP     = 3'd1,
    KIND_INS_AT  = 3'd2,
    KIND_REM_AT  = 3'd3,
    KIND_INS_MID = 3'd4,
    KIND_REM_MID = 3'd5,
    KIND_DUMP    = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic dump_start;
    logic dump_emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_dump;
    logic empty;
    logic dump_last;
  } stat_t;

endpackage

`default_nettype wire

### rtl/olir_ctrl.sv
`default_nettype none

module olir_ctrl
  import olir_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire stat_t stat,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_dump && !stat.empty) begin
          state_nxt = S_DUMP;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.out_free && stat.dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        if (stat.is_dump && !stat.empty) begin
          cmd.dump_start = 1'b1;
        end else begin
          cmd.exec = stat.out_free;
        end
      end
      S_DUMP: begin
        cmd.dump_emit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/olir_dp.sv
`default_nettype none

module olir_dp
  import olir_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [KIND_W-1:0]          in_kind,
  input  wire logic [POS_W-1:0]           in_position,
  input  wire logic signed [WORD_W-1:0]   in_word,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [STATUS_W-1:0]             out_status,
  output logic [COUNT_W-1:0]              out_count,
  output logic signed [WORD_W-1:0]        out_element,
  output logic                            out_element_valid,
  output logic                            out_last,
  input  wire cmd_t                       cmd,
  output stat_t                           stat
);

  localparam int HW = $clog2(CAPACITY + 1);
  localparam int CW = (HW > POS_W) ? HW : POS_W;

  logic [KIND_W-1:0]        op_kind_r;
  logic [POS_W-1:0]         op_pos_r;
  logic signed [WORD_W-1:0] op_word_r;

  logic [HW-1:0] held_r;
  logic [HW-1:0] held_nxt;
  logic [HW-1:0] rem_r;
  logic [HW-1:0] rem_nxt;

  logic signed [WORD_W-1:0] cells_r   [CAPACITY];
  logic signed [WORD_W-1:0] cells_nxt [CAPACITY];
  logic signed [WORD_W-1:0] up        [CAPACITY];
  logic signed [WORD_W-1:0] dn        [CAPACITY];

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic signed [WORD_W-1:0] out_element_r;
  logic                     out_element_valid_r;
  logic                     out_last_r;

  logic [CW-1:0] held_x;
  logic [CW-1:0] idx;
  logic          is_ins;
  logic          is_rem;
  status_t       op_status;
  logic          do_ins;
  logic          do_rem;
  logic          load;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind_r <= in_kind;
      op_pos_r  <= in_position;
      op_word_r <= in_word;
    end
  end

  assign held_x = CW'(held_r);

  always_comb begin
    idx    = CW'(op_pos_r);
    is_ins = 1'b0;
    is_rem = 1'b0;
    case (op_kind_r)
      KIND_PUSH: begin
        is_ins = 1'b1;
        idx    = held_x;
      end
      KIND_POP: begin
        is_rem = 1'b1;
        idx    = held_x - CW'(1);
      end
      KIND_INS_AT: begin
        is_ins = 1'b1;
      end
      KIND_REM_AT: begin
        is_rem = 1'b1;
      end
      KIND_INS_MID: begin
        is_ins = 1'b1;
        idx    = held_x >> 1;
      end
      KIND_REM_MID: begin
        is_rem = 1'b1;
        idx    = held_x >> 1;
      end
      default: begin
        idx = CW'(op_pos_r);
      end
    endcase
  end

  always_comb begin
    op_status = ST_DONE;
    if (is_ins) begin
      if (held_x >= CW'(CAPACITY)) begin
        op_status = ST_FULL;
      end else if (idx > held_x) begin
        op_status = ST_BAD;
      end
    end else if (is_rem) begin
      if (held_r == '0 || idx >= held_x) begin
        op_status = ST_BAD;
      end
    end else if (op_kind_r != KIND_DUMP) begin
      op_status = ST_BAD;
    end
  end

  assign do_ins = cmd.exec && is_ins && (op_status == ST_DONE);
  assign do_rem = cmd.exec && is_rem && (op_status == ST_DONE);

  always_comb begin
    held_nxt = held_r;
    if (do_ins) begin
      held_nxt = held_r + HW'(1);
    end else if (do_rem) begin
      held_nxt = held_r - HW'(1);
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    if (cmd.dump_start) begin
      rem_nxt = held_r;
    end else if (cmd.dump_emit) begin
      rem_nxt = rem_r - HW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      rem_r  <= '0;
    end else begin
      held_r <= held_nxt;
      rem_r  <= rem_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);

    if (i + 1 < CAPACITY) begin : g_up
      assign up[i] = cells_r[i+1];
    end else begin : g_top
      assign up[i] = cells_r[i];
    end

    if (i > 0) begin : g_dn
      assign dn[i] = cells_r[i-1];
    end else begin : g_bot
      assign dn[i] = cells_r[i];
    end

    always_comb begin
      cells_nxt[i] = cells_r[i];
      if (do_ins) begin
        if (IDX == idx) begin
          cells_nxt[i] = op_word_r;
        end else if (IDX > idx) begin
          cells_nxt[i] = dn[i];
        end
      end else if (do_rem) begin
        if (IDX >= idx) begin
          cells_nxt[i] = up[i];
        end
      end else if (cmd.dump_emit) begin
        if (IDX == held_x - CW'(1)) begin
          cells_nxt[i] = cells_r[0];
        end else if (IDX < held_x) begin
          cells_nxt[i] = up[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  assign load = cmd.exec || cmd.dump_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_count_r <= COUNT_W'(CW'(held_nxt));
      if (cmd.dump_emit) begin
        out_status_r        <= ST_DONE;
        out_element_r       <= cells_r[0];
        out_element_valid_r <= 1'b1;
        out_last_r          <= (rem_r == HW'(1));
      end else begin
        out_status_r        <= op_status;
        out_element_r       <= '0;
        out_element_valid_r <= 1'b0;
        out_last_r          <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_count         = out_count_r;
  assign out_element       = out_element_r;
  assign out_element_valid = out_element_valid_r;
  assign out_last          = out_last_r;

  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.is_dump   = (op_kind_r == KIND_DUMP);
  assign stat.empty     = (held_r == '0);
  assign stat.dump_last = (rem_r == HW'(1));

endmodule

`default_nettype wire

### rtl/ordered_list_insert_remove.sv
// Channel   Direction  Handshake              Payload
// in_*      input      in_valid / in_ready    kind, position, word
// out_*     output     out_valid / out_ready  status, count, element, element_valid, last
//
// An edit item is first captured, then applied to the cell chain as the output
// register is loaded; the next item is taken while that result waits.
// A dump reads each entry from cell 0 while the chain rotates.
// Stalls on out_ready hold the controller in place; the input side waits in turn.
// Reset (rst_n low, synchronous) empties the list; cell contents are kept.
`default_nettype none

module ordered_list_insert_remove
  import olir_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [KIND_W-1:0]         in_kind,
  input  wire logic [POS_W-1:0]          in_position,
  input  wire logic signed [WORD_W-1:0]  in_word,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [STATUS_W-1:0]            out_status,
  output logic [COUNT_W-1:0]             out_count,
  output logic signed [WORD_W-1:0]       out_element,
  output logic                           out_element_valid,
  output logic                           out_last
);

  cmd_t  cmd;
  stat_t stat;

  olir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  olir_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_kind),
    .in_position       (in_position),
    .in_word           (in_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_count         (out_count),
    .out_element       (out_element),
    .out_element_valid (out_element_valid),
    .out_last          (out_last),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

`default_nettype wire

### rtl/olir_chk.sv
`default_nettype none

module olir_chk
  import olir_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic [KIND_W-1:0]         in_kind,
  input wire logic [POS_W-1:0]          in_position,
  input wire logic signed [WORD_W-1:0]  in_word,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [STATUS_W-1:0]       out_status,
  input wire logic [COUNT_W-1:0]        out_count,
  input wire logic signed [WORD_W-1:0]  out_element,
  input wire logic                      out_element_valid,
  input wire logic                      out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count)
      && $stable(out_element) && $stable(out_element_valid) && $stable(out_last))
    else $error("result changed while stalled");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_last && !out_element_valid)
    else $error("error result not a lone final item");

  a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_element_valid |-> out_element == '0 && out_last)
    else $error("edit result carries an element");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && CAPACITY < 32 |-> 32'(out_count) <= CAPACITY)
    else $error("count beyond capacity");

  a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_element_valid && !out_last
      |=> !(out_valid && out_element_valid) || $stable(out_count))
    else $error("count moved during dump");

endmodule

bind ordered_list_insert_remove olir_chk #(.CAPACITY(CAPACITY)) u_olir_chk (.*);

`default_nettype wire
